@@ design/wdcld_pkg.sv @@
package wdcld_pkg;

  localparam logic [7:0] OP_REP = 8'hC2;
  localparam logic [7:0] OP_SEP = 8'hE2;
  localparam logic [7:0] OP_BRK = 8'h00;
  localparam logic [7:0] OP_COP = 8'h02;
  localparam logic [7:0] OP_WDM = 8'h42;
  localparam logic [7:0] OP_STP = 8'hDB;
  localparam logic [7:0] OP_SBC_LONG_X = 8'hFF;

  // bit positions of the m and x flags in a REP/SEP operand (0x20, 0x10)
  localparam int unsigned P_ACCUM_BIT = 5;
  localparam int unsigned P_INDEX_BIT = 4;

  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 1;
  localparam logic [CFG_INDEX_W-1:0] CFG_STOP_ON_UNLIKELY = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ACCUM_WIDE_INIT  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_INDEX_WIDE_INIT  = 2'd2;

  localparam int unsigned IN_DATA_W  = 8;
  localparam int unsigned OUT_DATA_W = 40;
  localparam int unsigned OUT_USER_W = 2;

  typedef struct packed {
    logic [7:0]  held_opcode;
    logic [23:0] operand_accum;
    logic [1:0]  bytes_remaining;
    logic [1:0]  byte_position;
    logic        accum_mode;
    logic        index_mode;
    logic        skipping;
  } dec_state_t;

  typedef struct packed {
    logic [7:0]  opcode_byte;
    logic [23:0] operand_value;
    logic [2:0]  instr_length;
    logic        truncated;
    logic        aborted;
    logic        accum_wide;
    logic        index_wide;
  } dec_result_t;

  // standard 65816 length table, 8-bit modes
  function automatic logic [2:0] base_length(input logic [7:0] op);
    logic [2:0] n;
    unique case (op[3:0])
      4'h8, 4'hA, 4'hB: n = 3'd1;
      4'h9:             n = op[4] ? 3'd3 : 3'd2;
      4'hC, 4'hD, 4'hE: n = 3'd3;
      4'hF:             n = 3'd4;
      default:          n = 3'd2;
    endcase
    unique case (op)
      8'h20, 8'h44, 8'h54, 8'h62, 8'h82, 8'hF4: n = 3'd3;
      8'h22, 8'h5C:                             n = 3'd4;
      8'h40, 8'h60:                             n = 3'd1;
      default: ;
    endcase
    return n;
  endfunction

  function automatic logic is_unlikely(input logic [7:0] op);
    return (op[3:0] == 4'h3) || (op == OP_BRK) || (op == OP_COP) ||
           (op == OP_WDM) || (op == OP_STP) || (op == OP_SBC_LONG_X);
  endfunction

endpackage

@@ design/wdc65816_instruction_length_decoder.sv @@
// 65816 instruction length decoder.
// Input stream (s_*): one code byte per beat, s_tlast on the last byte of a
// buffer. Output stream (m_*): one beat per finished instruction, or per
// partial instruction cut off by the buffer end (truncated), with opcode,
// little-endian operand, length and the accumulator/index width modes left
// by the instruction. REP/SEP change only the mode bits set in their operand.
// With stop_on_unlikely set, an unlikely opcode is reported as aborted and
// the rest of its buffer is dropped without output.
// Timing: a byte is registered on entry and decoded into the output register
// on the next edge. One byte per cycle is sustained while the output is not
// stalled; the single decode step between the input and output registers
// sets this figure.
// Stall: while m_tready is low and a result is held, the input register
// still takes one byte; after that s_tready drops until the result leaves.
// Reset: clears all buffered beats and decode state, stop_on_unlikely and
// the live mode bits go to zero. Write config (cfg_we) only while the
// block is idle; a mode init write loads the live mode.
module wdc65816_instruction_length_decoder (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [wdcld_pkg::IN_DATA_W-1:0]     s_tdata,  // [7:0] code_byte
  input  logic                                s_tlast,  // end_of_buffer
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // [7:0] opcode_byte, [31:8] operand_value, [34:32] instr_length,
  // [35] accum_wide, [36] index_wide, [39:37] zero
  output logic [wdcld_pkg::OUT_DATA_W-1:0]    m_tdata,
  output logic [wdcld_pkg::OUT_USER_W-1:0]    m_tuser,  // [0] truncated, [1] aborted
  input  logic                                cfg_we,
  input  logic [wdcld_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [wdcld_pkg::CFG_DATA_W-1:0]    cfg_data
);

  logic                  in_valid;
  logic [7:0]            in_byte;
  logic                  in_last;
  logic                  stop_on_unlikely;
  wdcld_pkg::dec_state_t state;
  wdcld_pkg::dec_state_t state_dec;
  wdcld_pkg::dec_state_t state_next;
  wdcld_pkg::dec_result_t res;
  wdcld_pkg::dec_result_t out_res;
  logic                  emit;
  logic                  out_free;
  logic                  advance;

  assign out_free = !m_tvalid || m_tready;
  assign advance  = in_valid && out_free;
  assign s_tready = !in_valid || out_free;

  wdcld_decode u_decode (
    .cur              (state),
    .code_byte        (in_byte),
    .end_of_buffer    (in_last),
    .stop_on_unlikely (stop_on_unlikely),
    .nxt              (state_dec),
    .emit             (emit),
    .res              (res)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
  end

  // advance on a decoded beat, then let a mode init write load the live mode
  always_comb begin
    state_next = advance ? state_dec : state;
    if (cfg_we) begin
      unique case (cfg_index)
        wdcld_pkg::CFG_ACCUM_WIDE_INIT: state_next.accum_mode = cfg_data[0];
        wdcld_pkg::CFG_INDEX_WIDE_INIT: state_next.index_mode = cfg_data[0];
        default: ;
      endcase
    end
  end

  // decode state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= '0;
      stop_on_unlikely <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we && (cfg_index == wdcld_pkg::CFG_STOP_ON_UNLIKELY)) begin
        stop_on_unlikely <= cfg_data[0];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= advance && emit;
    end
    if (advance && emit) out_res <= res;
  end

  assign m_tdata = {3'b000, out_res.index_wide, out_res.accum_wide, out_res.instr_length,
                    out_res.operand_value, out_res.opcode_byte};
  assign m_tuser = {out_res.aborted, out_res.truncated};

`ifndef NO_ASSERTIONS
  a_len_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[34:32] != 3'd0) && (m_tdata[34:32] <= 3'd4))
    else $error("instruction length out of range");

  a_skip_idle: assert property (@(posedge clk) disable iff (rst)
    state.skipping |-> (state.bytes_remaining == 2'd0))
    else $error("skipping while an instruction is open");

  a_emit_clears: assert property (@(posedge clk) disable iff (rst)
    (advance && emit && !cfg_we) |=> (state.bytes_remaining == 2'd0))
    else $error("instruction state not cleared after result");

  a_single_zero_operand: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tdata[34:32] == 3'd1)) |-> (m_tdata[31:8] == 24'd0))
    else $error("one-byte instruction carries an operand");
`endif

endmodule

@@ design/wdcld_decode.sv @@
module wdcld_decode (
  input  wdcld_pkg::dec_state_t  cur,
  input  logic [7:0]             code_byte,
  input  logic                   end_of_buffer,
  input  logic                   stop_on_unlikely,
  output wdcld_pkg::dec_state_t  nxt,
  output logic                   emit,
  output wdcld_pkg::dec_result_t res
);

  logic [2:0]  full_len;
  logic [23:0] acc_new;
  logic [1:0]  pos_new;
  logic [1:0]  rem_new;
  logic [7:0]  e_op;
  logic [23:0] e_operand;
  logic [2:0]  e_len;
  logic        e_trunc;
  logic        ab;
  logic        accum_after;
  logic        index_after;

  always_comb begin
    full_len = wdcld_pkg::base_length(code_byte);
    if ((code_byte[4:0] == 5'h09) && cur.accum_mode) full_len = full_len + 3'd1;
    if (((code_byte == 8'hA0) || (code_byte == 8'hA2) || (code_byte == 8'hC0) ||
         (code_byte == 8'hE0)) && cur.index_mode) full_len = full_len + 3'd1;

    acc_new = cur.operand_accum;
    unique case (cur.byte_position)
      2'd1:    acc_new[7:0]   = code_byte;
      2'd2:    acc_new[15:8]  = code_byte;
      2'd3:    acc_new[23:16] = code_byte;
      default: ;
    endcase
    pos_new = cur.byte_position + 2'd1;
    rem_new = cur.bytes_remaining - 2'd1;
  end

  always_comb begin
    nxt       = cur;
    emit      = 1'b0;
    e_op      = code_byte;
    e_operand = '0;
    e_len     = full_len;
    e_trunc   = 1'b0;
    if (cur.skipping) begin
      nxt.skipping = !end_of_buffer;
    end else if (cur.bytes_remaining == 2'd0) begin
      if (full_len <= 3'd1) begin
        emit  = 1'b1;
        e_len = 3'd1;
      end else if (end_of_buffer) begin
        emit    = 1'b1;
        e_trunc = 1'b1;
      end else begin
        nxt.held_opcode     = code_byte;
        nxt.operand_accum   = '0;
        nxt.bytes_remaining = full_len[1:0] - 2'd1;
        nxt.byte_position   = 2'd1;
      end
    end else begin
      nxt.operand_accum   = acc_new;
      nxt.byte_position   = pos_new;
      nxt.bytes_remaining = rem_new;
      if ((rem_new == 2'd0) || end_of_buffer) begin
        emit      = 1'b1;
        e_op      = cur.held_opcode;
        e_operand = acc_new;
        e_len     = ((pos_new == 2'd0) ? 3'd4 : {1'b0, pos_new}) + {1'b0, rem_new};
        e_trunc   = rem_new != 2'd0;
        nxt.held_opcode     = '0;
        nxt.operand_accum   = '0;
        nxt.bytes_remaining = '0;
        nxt.byte_position   = '0;
      end
    end

    // REP sets, SEP clears only the wide-mode bits named in the operand
    accum_after = cur.accum_mode;
    index_after = cur.index_mode;
    if (e_op == wdcld_pkg::OP_REP) begin
      if (e_operand[wdcld_pkg::P_ACCUM_BIT]) accum_after = 1'b1;
      if (e_operand[wdcld_pkg::P_INDEX_BIT]) index_after = 1'b1;
    end else if (e_op == wdcld_pkg::OP_SEP) begin
      if (e_operand[wdcld_pkg::P_ACCUM_BIT]) accum_after = 1'b0;
      if (e_operand[wdcld_pkg::P_INDEX_BIT]) index_after = 1'b0;
    end
    ab = stop_on_unlikely && wdcld_pkg::is_unlikely(e_op);

    if (emit) begin
      nxt.accum_mode = accum_after;
      nxt.index_mode = index_after;
      if (ab && !end_of_buffer) nxt.skipping = 1'b1;
    end

    res.opcode_byte   = e_op;
    res.operand_value = e_operand;
    res.instr_length  = e_len;
    res.truncated     = e_trunc;
    res.aborted       = ab;
    res.accum_wide    = accum_after;
    res.index_wide    = index_after;
  end

endmodule
